FILE: design/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared types for the edge-aware 3x3 box blur
// Pixel layout, result tag and window span flags used across the core.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int ROW_W     = 16;
   localparam int COL_OUT_W = 10;

   // blue in the low byte, then green, then red
   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
      logic                 last;
      logic                 eoi;
   } tag_type;

   // window rows/columns left out of the mean
   typedef struct packed {
      logic top_skip;
      logic left_skip;
   } span_type;

endpackage

FILE: design/box_blur_3x3_edge_aware_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core: streaming edge-aware 3x3 box blur
// Takes one RGB pixel a clock in raster order, while the input is not held
// back, and returns the rounded mean of each channel over the in-image part of
// its 3x3 neighbourhood. Output pixel (r-1,c-1) leaves for input (r,c); the
// last column and the last row are flushed as they complete, up to four words
// per input. The mean unit takes one word per clock while its output is not
// stalled, so a pixel holds the input until every word it produces is taken.
// A word passes the stage-one register, the window and both mean stages
// before it leaves. The two rows above live in one line memory of MAX_WIDTH
// entries, read as each pixel is accepted; no clearing pass after reset.
// A register write restarts the image at row 0, column 0.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // blue_in, green_in, red_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // blue_out, green_out, red_out, out_row, out_col
   output logic        rsp_tlast,    // last_of_run
   output logic        rsp_tuser,    // end_of_image
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bb3_pkg::*;

   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int WIDTH_REG_W  = 11;
   localparam int RSP_TDATA_W  = 56;
   localparam int RES_N        = 4;
   localparam int RES_ABOVE      = 0;
   localparam int RES_ABOVE_EDGE = 1;
   localparam int RES_ROW        = 2;
   localparam int RES_ROW_EDGE   = 3;
   localparam int LINE_ABOVE     = 0;
   localparam int LINE_TWO_ABOVE = 1;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [ROW_W-1:0]       HEIGHT_RESET = ROW_W'(480);

   typedef enum logic {CSR_WIDTH, CSR_HEIGHT} csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             row_ge1;
      logic             row_ge2;
      logic             col_ge1;
      logic             col_ge2;
      logic             last_col;
      logic             last_row;
   } s1_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             top_skip;
      logic             left_skip;
   } job_type;

   // configuration
   csr_index_type          csr_index;
   logic                   csr_write;
   logic [WIDTH_REG_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0]       height_ff, height_in;
   logic [31:0]            width_last32;
   logic [COL_W-1:0]       col_last;
   logic [ROW_W-1:0]       row_last;

   // position of the next pixel
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             at_last_col, at_last_row, req_accept;

   // stage one: line memory read in flight
   logic      s1_valid_ff, s1_valid_in, s1_move;
   s1_type    s1_ff, s1_in;
   pixel_type s1_pix_ff;

   // stage two: window and pending results
   pixel_type [8:0]  win_ff, win_in;
   logic [RES_N-1:0] job_mask_ff, job_mask_in, load_mask;
   job_type          job_ff, job_in;
   logic             job_busy, job_free;
   logic [RES_N-1:0] issue_low;
   logic             issue_last, issue_fire;
   span_type         issue_span;
   tag_type          issue_tag;
   logic [31:0]      col_c32, col_m32;
   logic [ROW_W-1:0] row_m1;

   pixel_type [1:0] line_rd, line_wr;
   logic            mean_ready;
   pixel_type       out_pix;
   tag_type         out_tag;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      unique case (csr_index)
         CSR_WIDTH: begin
            csr_prdata = 32'(width_ff);
            if (csr_write) begin
               width_in = csr_pwdata[WIDTH_REG_W-1:0];
            end
         end
         CSR_HEIGHT: begin
            csr_prdata = 32'(height_ff);
            if (csr_write) begin
               height_in = csr_pwdata[ROW_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // effective image size
   always_comb begin
      if (width_ff < WIDTH_REG_W'(2)) begin
         width_last32 = 32'd1;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_last32 = 32'(MAX_WIDTH - 1);
      end else begin
         width_last32 = 32'(width_ff) - 32'd1;
      end
   end
   assign col_last = width_last32[COL_W-1:0];
   assign row_last = (height_ff < ROW_W'(2)) ? ROW_W'(1) : height_ff - ROW_W'(1);

   assign at_last_col = (col_ff == col_last);
   assign at_last_row = (row_ff == row_last);

   // handshake chain
   assign job_busy   = (job_mask_ff != '0);
   assign issue_fire = job_busy && mean_ready;
   assign job_free   = !job_busy || (issue_fire && issue_last);
   assign s1_move    = s1_valid_ff && job_free;
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in     = req_tready ? req_tvalid : s1_valid_ff;
      s1_in.row       = row_ff;
      s1_in.col       = col_ff;
      s1_in.row_ge1   = (row_ff != '0);
      s1_in.row_ge2   = ((row_ff >> 1) != '0);
      s1_in.col_ge1   = (col_ff != '0);
      s1_in.col_ge2   = ((col_ff >> 1) != '0);
      s1_in.last_col  = at_last_col;
      s1_in.last_row  = at_last_row;
   end

   // next column reads while the previous one writes back
   bb3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (line_rd),
      .wr_en   (s1_move),
      .wr_addr (s1_ff.col),
      .wr_data (line_wr)
   );

   always_comb begin
      line_wr[LINE_TWO_ABOVE] = line_rd[LINE_ABOVE];
      line_wr[LINE_ABOVE]     = s1_pix_ff;
   end

   // window shift and result mask
   always_comb begin
      win_in = win_ff;
      if (s1_move) begin
         for (int rw = 0; rw < 3; rw++) begin
            win_in[rw*3]     = win_ff[rw*3 + 1];
            win_in[rw*3 + 1] = win_ff[rw*3 + 2];
         end
         win_in[2] = line_rd[LINE_TWO_ABOVE];
         win_in[5] = line_rd[LINE_ABOVE];
         win_in[8] = s1_pix_ff;
      end
   end

   always_comb begin
      load_mask[RES_ABOVE]      = s1_ff.row_ge1 && s1_ff.col_ge1;
      load_mask[RES_ABOVE_EDGE] = s1_ff.row_ge1 && s1_ff.last_col;
      load_mask[RES_ROW]        = s1_ff.last_row && s1_ff.col_ge1;
      load_mask[RES_ROW_EDGE]   = s1_ff.last_row && s1_ff.last_col;
      job_in.row       = s1_ff.row;
      job_in.col       = s1_ff.col;
      job_in.top_skip  = !s1_ff.row_ge2;
      job_in.left_skip = !s1_ff.col_ge2;
   end

   assign issue_low  = job_mask_ff & (~job_mask_ff + RES_N'(1));
   assign issue_last = ((job_mask_ff & ~issue_low) == '0);

   always_comb begin
      job_mask_in = job_mask_ff;
      if (issue_fire) begin
         job_mask_in = job_mask_ff & ~issue_low;
      end
      if (s1_move) begin
         job_mask_in = load_mask;
      end
   end

   // pick the next pending result
   always_comb begin
      col_c32 = 32'(job_ff.col);
      col_m32 = 32'(job_ff.col) - 32'd1;
      row_m1  = job_ff.row - ROW_W'(1);
      issue_tag.last = issue_last;
      if (job_mask_ff[RES_ABOVE]) begin
         issue_span.top_skip  = job_ff.top_skip;
         issue_span.left_skip = job_ff.left_skip;
         issue_tag.row        = row_m1;
         issue_tag.col        = col_m32[COL_OUT_W-1:0];
         issue_tag.eoi        = 1'b0;
      end else if (job_mask_ff[RES_ABOVE_EDGE]) begin
         issue_span.top_skip  = job_ff.top_skip;
         issue_span.left_skip = 1'b1;
         issue_tag.row        = row_m1;
         issue_tag.col        = col_c32[COL_OUT_W-1:0];
         issue_tag.eoi        = 1'b0;
      end else if (job_mask_ff[RES_ROW]) begin
         issue_span.top_skip  = 1'b1;
         issue_span.left_skip = job_ff.left_skip;
         issue_tag.row        = job_ff.row;
         issue_tag.col        = col_m32[COL_OUT_W-1:0];
         issue_tag.eoi        = 1'b0;
      end else begin
         issue_span.top_skip  = 1'b1;
         issue_span.left_skip = 1'b1;
         issue_tag.row        = job_ff.row;
         issue_tag.col        = col_c32[COL_OUT_W-1:0];
         issue_tag.eoi        = 1'b1;
      end
   end

   bb3_mean u_mean (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_busy),
      .in_ready  (mean_ready),
      .in_win    (win_ff),
      .in_span   (issue_span),
      .in_tag    (issue_tag),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (out_pix),
      .out_tag   (out_tag)
   );

   assign rsp_tdata = RSP_TDATA_W'({out_tag.col, out_tag.row, out_pix});
   assign rsp_tlast = out_tag.last;
   assign rsp_tuser = out_tag.eoi;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         job_mask_ff <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         job_mask_ff <= job_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff     <= s1_in;
         s1_pix_ff <= req_tdata;
      end
      if (s1_move) begin
         job_ff <= job_in;
      end
      win_ff <= win_in;
   end

   // write-back never lands on the column being read
   a_line_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && s1_move && (col_ff == s1_ff.col)))
      else $error("line memory read and write hit the same column");

   a_job_keeps_pending: assert property (@(posedge clock) disable iff (reset)
      (issue_fire && !issue_last) |=> job_busy)
      else $error("pending results dropped");

   a_eoi_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("end of image word is not last of its run");

   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (col_ff == '0 && row_ff == '0))
      else $error("register write did not restart the image");

endmodule

FILE: design/bb3_line_store.sv
// ----------------------------------------------------------------------------
// bb3_line_store: line memory for the two rows above
// One entry per column, holding the pixel two rows up and the one just above.
// ----------------------------------------------------------------------------
module bb3_line_store #(
   parameter  int DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output bb3_pkg::pixel_type [1:0]     rd_data,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  bb3_pkg::pixel_type [1:0]     wr_data
);
   import bb3_pkg::*;

   pixel_type [1:0] store_ff [DEPTH];
   pixel_type [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bb3_mean.sv
// ----------------------------------------------------------------------------
// bb3_mean: rounded neighbourhood mean, two stages
// Stage one sums the selected window pixels, stage two divides by the pixel
// count with a reciprocal multiply and holds the result word.
// ----------------------------------------------------------------------------
module bb3_mean (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  bb3_pkg::pixel_type [8:0] in_win,
   input  bb3_pkg::span_type        in_span,
   input  bb3_pkg::tag_type         in_tag,
   output logic                     out_valid,
   input  logic                     out_ready,
   output bb3_pkg::pixel_type       out_pix,
   output bb3_pkg::tag_type         out_tag
);
   import bb3_pkg::*;

   localparam int NUM_CH      = 3;
   localparam int SUM_W       = 12;
   localparam int NUM_W       = 13;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 22;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int RECIP_FOUR  = (1 << RECIP_SHIFT) / 8;
   localparam int RECIP_SIX   = ((1 << RECIP_SHIFT) + 11) / 12;
   localparam int RECIP_NINE  = ((1 << RECIP_SHIFT) + 17) / 18;

   typedef enum logic [1:0] {AREA_FOUR, AREA_SIX, AREA_NINE} area_type;

   function automatic logic [RECIP_W-1:0] area_recip(area_type area);
      logic [RECIP_W-1:0] r;
      case (area)
         AREA_FOUR: r = RECIP_W'(RECIP_FOUR);
         AREA_SIX:  r = RECIP_W'(RECIP_SIX);
         AREA_NINE: r = RECIP_W'(RECIP_NINE);
         default:   r = RECIP_W'(RECIP_FOUR);
      endcase
      return r;
   endfunction

   function automatic logic [NUM_W-1:0] area_count(area_type area);
      logic [NUM_W-1:0] n;
      case (area)
         AREA_FOUR: n = NUM_W'(4);
         AREA_SIX:  n = NUM_W'(6);
         AREA_NINE: n = NUM_W'(9);
         default:   n = NUM_W'(4);
      endcase
      return n;
   endfunction

   logic             a_valid_ff, a_valid_in;
   logic [NUM_W-1:0] a_num_ff [NUM_CH];
   logic [NUM_W-1:0] a_num_in [NUM_CH];
   area_type         a_area_ff, a_area_in;
   tag_type          a_tag_ff, a_tag_in;
   logic             b_valid_ff, b_valid_in;
   pixel_type        b_pix_ff, b_pix_in;
   tag_type          b_tag_ff, b_tag_in;

   logic             b_move, a_free, a_load;
   logic [SUM_W-1:0] sum [NUM_CH];
   logic [PROD_W-1:0] prod [NUM_CH];

   assign b_move   = !b_valid_ff || out_ready;
   assign a_free   = !a_valid_ff || b_move;
   assign a_load   = a_free && in_valid;
   assign in_ready = a_free;

   // stage one: window sum
   always_comb begin
      if (in_span.top_skip && in_span.left_skip) begin
         a_area_in = AREA_FOUR;
      end else if (in_span.top_skip || in_span.left_skip) begin
         a_area_in = AREA_SIX;
      end else begin
         a_area_in = AREA_NINE;
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum[ch] = '0;
         for (int rw = 0; rw < 3; rw++) begin
            for (int cl = 0; cl < 3; cl++) begin
               if ((rw != 0 || !in_span.top_skip) && (cl != 0 || !in_span.left_skip)) begin
                  sum[ch] = sum[ch] + SUM_W'(in_win[rw*3 + cl][ch*CH_W +: CH_W]);
               end
            end
         end
         a_num_in[ch] = {sum[ch], 1'b0} + area_count(a_area_in);
      end
      a_tag_in   = in_tag;
      a_valid_in = a_free ? in_valid : a_valid_ff;
   end

   // stage two: divide by 2*count
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         prod[ch] = PROD_W'(a_num_ff[ch]) * PROD_W'(area_recip(a_area_ff));
         b_pix_in[ch*CH_W +: CH_W] = prod[ch][RECIP_SHIFT +: CH_W];
      end
      b_tag_in   = a_tag_ff;
      b_valid_in = b_move ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_num_ff  <= a_num_in;
         a_area_ff <= a_area_in;
         a_tag_ff  <= a_tag_in;
      end
      if (b_move && a_valid_ff) begin
         b_pix_ff <= b_pix_in;
         b_tag_ff <= b_tag_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_pix   = b_pix_ff;
   assign out_tag   = b_tag_ff;

endmodule

FILE: verif/box_blur_3x3_edge_aware_core_test.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core_test: self-checking bench for the 3x3 box blur
// Streams raster-order RGB pixels through the core under several image sizes,
// including out-of-range sizes, the maximum height, restarts and back-to-back
// images. A built-in blur predictor computes every expected word; each word is
// checked field by field while one, both or neither stream side stalls at random.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bb3_pkg::*;

   localparam int MAX_W = 1024;
   localparam int LIMIT = 2_000_000;
   localparam int SETTLE = 12;
   localparam logic [2:0] WIDTH_ADDR = 3'd0;
   localparam logic [2:0] HEIGHT_ADDR = 3'd4;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_CHECKER} fill_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;

   typedef struct {
      logic [CH_W-1:0]      blue;
      logic [CH_W-1:0]      green;
      logic [CH_W-1:0]      red;
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
      logic                 last;
      logic                 eoi;
   } blur_word_type;

   class blur_checker;
      logic [10:0]   width_reg;
      logic [15:0]   height_reg;
      pixel_type     above[MAX_W];
      pixel_type     two_above[MAX_W];
      pixel_type     window[9];
      int unsigned   row_pos;
      int unsigned   col_pos;
      blur_word_type blurred_due[$];
      int            errors;

      function new();
         width_reg = 11'd640;
         height_reg = 16'd480;
         row_pos = 0;
         col_pos = 0;
         errors = 0;
         foreach (window[i]) window[i] = '0;
         foreach (above[i]) begin
            above[i] = '0;
            two_above[i] = '0;
         end
      endfunction

      function void write_reg(logic [2:0] addr, logic [31:0] data);
         if (addr == WIDTH_ADDR) begin
            width_reg = data[10:0];
         end else if (addr == HEIGHT_ADDR) begin
            height_reg = data[15:0];
         end
         row_pos = 0;
         col_pos = 0;
      endfunction

      function logic [CH_W-1:0] window_mean(int ch, int r0, int c0);
         int unsigned sum;
         int unsigned count;
         sum = 0;
         count = 0;
         for (int i = r0; i < 3; i++) begin
            for (int j = c0; j < 3; j++) begin
               sum += window[i*3+j][ch*CH_W +: CH_W];
               count++;
            end
         end
         return CH_W'((2 * sum + count) / (2 * count));
      endfunction

      function blur_word_type blurred(int r0, int c0, int unsigned row,
                                      int unsigned col, logic eoi);
         blur_word_type w;
         w.blue = window_mean(0, r0, c0);
         w.green = window_mean(1, r0, c0);
         w.red = window_mean(2, r0, c0);
         w.row = row[ROW_W-1:0];
         w.col = col[COL_OUT_W-1:0];
         w.last = 1'b0;
         w.eoi = eoi;
         return w;
      endfunction

      function void note_pixel(pixel_type pix);
         blur_word_type run[4];
         int            n;
         int unsigned   w;
         int unsigned   h;
         int unsigned   r;
         int unsigned   c;
         int            top;
         int            left;
         logic          last_col;
         logic          last_row;
         w = (width_reg < 2) ? 2 : ((width_reg > MAX_W) ? MAX_W : width_reg);
         h = (height_reg < 2) ? 2 : height_reg;
         r = (row_pos >= h) ? h - 1 : row_pos;
         c = (col_pos >= w) ? w - 1 : col_pos;
         for (int i = 0; i < 3; i++) begin
            window[i*3] = window[i*3+1];
            window[i*3+1] = window[i*3+2];
         end
         window[2] = two_above[c];
         window[5] = above[c];
         window[8] = pix;
         two_above[c] = above[c];
         above[c] = pix;
         top = (r >= 2) ? 0 : 1;
         left = (c >= 2) ? 0 : 1;
         last_col = (c == w - 1);
         last_row = (r == h - 1);
         n = 0;
         if (r >= 1) begin
            if (c >= 1) begin
               run[n] = blurred(top, left, r - 1, c - 1, 1'b0);
               n++;
            end
            if (last_col) begin
               run[n] = blurred(top, 1, r - 1, w - 1, 1'b0);
               n++;
            end
         end
         if (last_row) begin
            if (c >= 1) begin
               run[n] = blurred(1, left, r, c - 1, 1'b0);
               n++;
            end
            if (last_col) begin
               run[n] = blurred(1, 1, r, w - 1, 1'b1);
               n++;
            end
         end
         if (n > 0) run[n-1].last = 1'b1;
         for (int k = 0; k < n; k++) blurred_due.push_back(run[k]);
         if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_word(logic [55:0] data, logic last, logic eoi);
         blur_word_type want;
         if (blurred_due.size() == 0) begin
            $display("%0t: word with none expected, expected nothing got %h", $time, data);
            errors++;
            return;
         end
         want = blurred_due.pop_front();
         compare("blue", want.blue, data[7:0]);
         compare("green", want.green, data[15:8]);
         compare("red", want.red, data[23:16]);
         compare("row", want.row, data[39:24]);
         compare("col", want.col, data[49:40]);
         compare("last", want.last, last);
         compare("eoi", want.eoi, eoi);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // blue_in, green_in, red_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // blue_out, green_out, red_out, out_row, out_col
   logic        rsp_tlast;         // last_of_run
   logic        rsp_tuser;         // end_of_image
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int unsigned cycle_count = 0;
   blur_checker blur = new();

   box_blur_3x3_edge_aware_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) blur.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
         if (req_tvalid && req_tready) blur.note_pixel(req_tdata);
      end
   end

   task automatic set_idling(idling_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 49;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 49;
         end
         default: begin
            send_idle_pct = 13;
            recv_stall_pct = 13;
         end
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blur.blurred_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      blur.write_reg(addr, data);
      @(posedge clock);
   endtask

   task automatic send_pixel(pixel_type pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic feed(int unsigned count, fill_type fill, bit pauses);
      pixel_type pix;
      for (int unsigned i = 0; i < count; i++) begin
         case (fill)
            FILL_ZERO:    pix = '0;
            FILL_FULL:    pix = '1;
            FILL_CHECKER: pix = i[0] ? '1 : '0;
            default:      pix = pixel_type'($urandom);
         endcase
         if (pauses && $urandom_range(39) == 0) drain();
         send_pixel(pix);
      end
   endtask

   task automatic run_image(logic [31:0] w_reg, logic [31:0] h_reg, int unsigned count,
                            fill_type fill, idling_type mode, bit pauses);
      drain();
      repeat (SETTLE) @(posedge clock);
      write_csr(WIDTH_ADDR, w_reg);
      write_csr(HEIGHT_ADDR, h_reg);
      set_idling(mode);
      feed(count, fill, pauses);
   endtask

   initial begin
      int unsigned random_count;
      int unsigned w_reg;
      int unsigned h_reg;
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned count;
      int unsigned pick;
      int          phase;
      random_count = 0;
      phase = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset sizes, part of the first row
      set_idling(IDLE_SENDER);
      feed(16, FILL_RANDOM, 0);

      run_image(2, 2, 4, FILL_FULL, IDLE_NONE, 0);
      run_image(0, 1, 4, FILL_ZERO, IDLE_RECEIVER, 0);
      run_image(1, 0, 4, FILL_CHECKER, IDLE_BOTH, 0);
      run_image(3, 3, 5, FILL_RANDOM, IDLE_SENDER, 0);
      drain();
      feed(4, FILL_RANDOM, 0);

      while (random_count < 160) begin
         pick = $urandom_range(99);
         w_reg = (pick < 6) ? $urandom_range(1, 0) : $urandom_range(12, 2);
         pick = $urandom_range(99);
         if (pick < 6) begin
            h_reg = $urandom_range(1, 0);
         end else if (pick < 10) begin
            h_reg = 65535;
         end else begin
            h_reg = $urandom_range(6, 2);
         end
         w_eff = (w_reg < 2) ? 2 : w_reg;
         h_eff = (h_reg < 2) ? 2 : h_reg;
         if (h_reg == 65535) begin
            count = $urandom_range(3 * w_eff, 1);
         end else if ($urandom_range(7) == 0) begin
            count = $urandom_range(w_eff * h_eff - 1, 1);
         end else begin
            count = w_eff * h_eff * $urandom_range(2, 1);
         end
         phase = phase + 1;
         run_image(w_reg, h_reg, count, FILL_RANDOM, idling_type'(phase % 4), 1);
         random_count += count;
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (blur.errors == 0 && blur.blurred_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/bb3_pkg.sv
design/bb3_line_store.sv
design/bb3_mean.sv
design/box_blur_3x3_edge_aware_core.sv
verif/box_blur_3x3_edge_aware_core_test.sv
